FILE: hw/rtl/assert_macros.svh
// Assertion macros for the port-level checker of the move planner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define TAMP_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("move planner assertion failed");

// Check what must hold in the cycle after a reset cycle.
`define TAMP_ASSERT_RST(name, clk, rstn, expr) \
    name: assert property (@(posedge clk) !rstn |=> expr) \
        else $error("move planner reset assertion failed");

`endif

FILE: hw/rtl/tamp_pkg.sv
// Shared types, codes and constants of the two-axis move planner.
package tamp_pkg;

    localparam int unsigned POS_BITS_DEF = 24;
    localparam int unsigned LIMIT_W      = 23;
    localparam int unsigned RATE_W       = 20;
    localparam int unsigned CFG_W        = 23;
    localparam int unsigned CFG_IDX_W    = 2;
    localparam int unsigned REQ_W        = 2;
    localparam int unsigned STATUS_W     = 2;
    localparam int unsigned KIND_W       = 3;
    localparam int unsigned OUT_USER_W   = STATUS_W + KIND_W;
    // 1 ms duration floor: rate = steps * 1000
    localparam int unsigned RATE_SCALE   = 1000;
    localparam int unsigned SCALE_W      = 10;
    localparam int unsigned DIV_STEPS    = RATE_W;
    localparam int unsigned CNT_W        = $clog2(DIV_STEPS);

    localparam logic [LIMIT_W-1:0] LIMIT_RST = 23'h7F_FFFF;
    localparam logic [RATE_W-1:0]  RATE_RST  = 20'd1000;

    typedef enum logic [REQ_W-1:0] {
        REQ_MOVE  = 2'd0,
        REQ_HOME  = 2'd1,
        REQ_ABORT = 2'd2
    } t_req_type;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE          = 2'd0,
        ST_AT_TARGET     = 2'd1,
        ST_OUT_OF_BOUNDS = 2'd2
    } t_status;

    typedef enum logic [KIND_W-1:0] {
        CMD_NONE      = 3'd0,
        CMD_MOVE_BOTH = 3'd1,
        CMD_MOVE_X    = 3'd2,
        CMD_MOVE_Y    = 3'd3,
        CMD_HOME      = 3'd4,
        CMD_STOP_ALL  = 3'd5
    } t_cmd_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_LIMIT  = 2'd0,
        CFG_Y_LIMIT  = 2'd1,
        CFG_MAX_RATE = 2'd2
    } t_cfg_idx;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic eval;
        logic mag;
        logic mul;
        logic div_step;
        logic emit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic proceed;
    } t_dp_sts;

endpackage

FILE: hw/rtl/tamp_div.sv
// Radix-2 restoring divider producing one quotient bit per cycle while i_step is high.
module tamp_div #(
    parameter int unsigned POS_BITS = tamp_pkg::POS_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_load,
    input  logic                                  i_step,
    input  logic [POS_BITS+tamp_pkg::RATE_W-1:0]  i_num,
    input  logic [POS_BITS-1:0]                   i_den,
    output logic [tamp_pkg::RATE_W-1:0]           o_quot
);

    localparam int unsigned RW = tamp_pkg::RATE_W;

    // quotient fits RW bits, so the partial remainder starts at num >> RW
    logic [POS_BITS-1:0] r_rem;
    logic [RW-1:0]       r_q;
    logic [POS_BITS:0]   w_trial;
    logic [POS_BITS:0]   w_diff;
    logic                w_ge;

    assign w_trial = {r_rem, r_q[RW-1]};
    assign w_diff  = w_trial - {1'b0, i_den};
    assign w_ge    = w_trial >= {1'b0, i_den};
    assign o_quot  = r_q;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= i_num[POS_BITS+RW-1:RW];
            r_q   <= i_num[RW-1:0];
        end else if (i_step) begin
            r_rem <= w_ge ? w_diff[POS_BITS-1:0] : w_trial[POS_BITS-1:0];
            r_q   <= {r_q[RW-2:0], w_ge};
        end
    end

endmodule

FILE: hw/rtl/tamp_dp.sv
// Datapath: limits, tracked position, deltas, rate products and result register.
module tamp_dp #(
    parameter int unsigned POS_BITS = tamp_pkg::POS_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tamp_pkg::t_dp_cmd                   i_cmd,
    output tamp_pkg::t_dp_sts                   o_sts,
    input  logic [tamp_pkg::REQ_W-1:0]          i_req,
    input  logic signed [POS_BITS-1:0]          i_dest_x,
    input  logic signed [POS_BITS-1:0]          i_dest_y,
    input  logic                                i_cfg_wr_en,
    input  logic [tamp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tamp_pkg::CFG_W-1:0]          i_cfg_wr_data,
    output logic [tamp_pkg::STATUS_W-1:0]       o_status,
    output logic [tamp_pkg::KIND_W-1:0]         o_kind,
    output logic signed [POS_BITS:0]            o_move_dx,
    output logic signed [POS_BITS:0]            o_move_dy,
    output logic [tamp_pkg::RATE_W-1:0]         o_rate_x,
    output logic [tamp_pkg::RATE_W-1:0]         o_rate_y,
    output logic signed [POS_BITS-1:0]          o_now_x,
    output logic signed [POS_BITS-1:0]          o_now_y,
    output logic [POS_BITS-1:0]                 o_travel
);

    localparam int unsigned P  = POS_BITS;
    localparam int unsigned DW = POS_BITS + 1;
    localparam int unsigned LW = tamp_pkg::LIMIT_W;
    localparam int unsigned RW = tamp_pkg::RATE_W;
    localparam int unsigned CW = (POS_BITS > LW) ? POS_BITS : LW;
    localparam int unsigned PW = POS_BITS + RW;
    localparam int unsigned MW = POS_BITS + tamp_pkg::SCALE_W;
    localparam int unsigned FW = (MW > RW) ? MW : RW;

    // configuration and tracked state
    logic [LW-1:0]         r_x_limit;
    logic [LW-1:0]         r_y_limit;
    logic [RW-1:0]         r_max_rate;
    logic signed [P-1:0]   r_track_x, n_track_x;
    logic signed [P-1:0]   r_track_y, n_track_y;
    logic [P-1:0]          r_travel, n_travel;

    // working registers
    tamp_pkg::t_req_type   r_req;
    logic signed [P-1:0]   r_tx, r_ty;
    logic signed [DW-1:0]  r_dx, r_dy;
    logic                  r_oob;
    logic [P-1:0]          r_major, r_minor;
    logic                  r_x_major;
    logic [MW-1:0]         r_major_k, r_minor_k;

    // result register
    tamp_pkg::t_status     r_status, n_status;
    tamp_pkg::t_cmd_kind   r_kind, n_kind;
    logic signed [DW-1:0]  r_o_dx, n_o_dx;
    logic signed [DW-1:0]  r_o_dy, n_o_dy;
    logic [RW-1:0]         r_rate_x, n_rate_x;
    logic [RW-1:0]         r_rate_y, n_rate_y;

    logic signed [P-1:0]   w_tx_neg, w_ty_neg;
    logic [P-1:0]          w_tx_mag, w_ty_mag;
    logic                  w_oob;
    logic signed [DW-1:0]  w_dx, w_dy, w_dx_neg, w_dy_neg;
    logic [P-1:0]          w_ax, w_ay;
    logic                  w_x_major;
    logic                  w_moved;
    logic [PW-1:0]         w_prod;
    logic [MW-1:0]         w_major_k, w_minor_k;
    logic [RW-1:0]         w_quot;
    logic                  w_fast;
    logic [RW-1:0]         w_rate_maj, w_rate_min;

    // bounds check on the absolute target
    assign w_tx_neg = -r_tx;
    assign w_ty_neg = -r_ty;
    assign w_tx_mag = r_tx[P-1] ? $unsigned(w_tx_neg) : $unsigned(r_tx);
    assign w_ty_mag = r_ty[P-1] ? $unsigned(w_ty_neg) : $unsigned(r_ty);
    assign w_oob    = (CW'(w_tx_mag) > CW'(r_x_limit)) || (CW'(w_ty_mag) > CW'(r_y_limit));
    assign w_dx     = DW'(r_tx) - DW'(r_track_x);
    assign w_dy     = DW'(r_ty) - DW'(r_track_y);

    // delta magnitudes and major axis
    assign w_dx_neg  = -r_dx;
    assign w_dy_neg  = -r_dy;
    assign w_ax      = r_dx[DW-1] ? w_dx_neg[P-1:0] : r_dx[P-1:0];
    assign w_ay      = r_dy[DW-1] ? w_dy_neg[P-1:0] : r_dy[P-1:0];
    assign w_x_major = w_ax >= w_ay;
    assign w_moved   = (r_dx != '0) || (r_dy != '0);

    assign o_sts.proceed = (r_req == tamp_pkg::REQ_MOVE) && !r_oob && w_moved;

    // products: minor * max_rate feeds the divider, steps * 1000 the short-move rate
    assign w_prod    = PW'(r_minor) * PW'(r_max_rate);
    assign w_major_k = MW'(r_major) * MW'(tamp_pkg::RATE_SCALE);
    assign w_minor_k = MW'(r_minor) * MW'(tamp_pkg::RATE_SCALE);

    tamp_div #(
        .POS_BITS (POS_BITS)
    ) u_div (
        .i_clk  (i_clk),
        .i_load (i_cmd.mul),
        .i_step (i_cmd.div_step),
        .i_num  (w_prod),
        .i_den  (r_major),
        .o_quot (w_quot)
    );

    // major: lower of max_rate and steps * 1000; minor: minor * that rate / major
    assign w_fast     = FW'(r_major_k) < FW'(r_max_rate);
    assign w_rate_maj = w_fast ? RW'(r_major_k) :
                        ((r_max_rate == '0) ? RW'(1) : r_max_rate);
    assign w_rate_min = (r_minor == '0) ? '0 :
                        w_fast ? RW'(r_minor_k) :
                        ((w_quot == '0) ? RW'(1) : w_quot);

    always_comb begin
        n_status  = tamp_pkg::ST_DONE;
        n_kind    = tamp_pkg::CMD_NONE;
        n_o_dx    = '0;
        n_o_dy    = '0;
        n_rate_x  = '0;
        n_rate_y  = '0;
        n_track_x = r_track_x;
        n_track_y = r_track_y;
        n_travel  = r_travel;
        unique case (r_req)
            tamp_pkg::REQ_MOVE: begin
                if (r_oob) begin
                    n_status = tamp_pkg::ST_OUT_OF_BOUNDS;
                end else if (!w_moved) begin
                    n_status = tamp_pkg::ST_AT_TARGET;
                end else begin
                    if (r_dx != '0 && r_dy != '0) begin
                        n_kind = tamp_pkg::CMD_MOVE_BOTH;
                    end else if (r_dx != '0) begin
                        n_kind = tamp_pkg::CMD_MOVE_X;
                    end else begin
                        n_kind = tamp_pkg::CMD_MOVE_Y;
                    end
                    n_o_dx    = r_dx;
                    n_o_dy    = r_dy;
                    n_rate_x  = r_x_major ? w_rate_maj : w_rate_min;
                    n_rate_y  = r_x_major ? w_rate_min : w_rate_maj;
                    n_track_x = r_tx;
                    n_track_y = r_ty;
                    n_travel  = r_major;
                end
            end
            tamp_pkg::REQ_HOME: begin
                n_kind    = tamp_pkg::CMD_HOME;
                n_track_x = '0;
                n_track_y = '0;
                n_travel  = '0;
            end
            tamp_pkg::REQ_ABORT: begin
                n_kind = tamp_pkg::CMD_STOP_ALL;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_limit  <= tamp_pkg::LIMIT_RST;
            r_y_limit  <= tamp_pkg::LIMIT_RST;
            r_max_rate <= tamp_pkg::RATE_RST;
            r_track_x  <= '0;
            r_track_y  <= '0;
            r_travel   <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (tamp_pkg::t_cfg_idx'(i_cfg_idx))
                    tamp_pkg::CFG_X_LIMIT:  r_x_limit  <= i_cfg_wr_data[LW-1:0];
                    tamp_pkg::CFG_Y_LIMIT:  r_y_limit  <= i_cfg_wr_data[LW-1:0];
                    tamp_pkg::CFG_MAX_RATE: r_max_rate <= i_cfg_wr_data[RW-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.emit) begin
                r_track_x <= n_track_x;
                r_track_y <= n_track_y;
                r_travel  <= n_travel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= tamp_pkg::t_req_type'(i_req);
            r_tx  <= i_dest_x;
            r_ty  <= i_dest_y;
        end
        if (i_cmd.eval) begin
            r_dx  <= w_dx;
            r_dy  <= w_dy;
            r_oob <= w_oob;
        end
        if (i_cmd.mag) begin
            r_major   <= w_x_major ? w_ax : w_ay;
            r_minor   <= w_x_major ? w_ay : w_ax;
            r_x_major <= w_x_major;
        end
        if (i_cmd.mul) begin
            r_major_k <= w_major_k;
            r_minor_k <= w_minor_k;
        end
        if (i_cmd.emit) begin
            r_status <= n_status;
            r_kind   <= n_kind;
            r_o_dx   <= n_o_dx;
            r_o_dy   <= n_o_dy;
            r_rate_x <= n_rate_x;
            r_rate_y <= n_rate_y;
        end
    end

    assign o_status  = r_status;
    assign o_kind    = r_kind;
    assign o_move_dx = r_o_dx;
    assign o_move_dy = r_o_dy;
    assign o_rate_x  = r_rate_x;
    assign o_rate_y  = r_rate_y;
    assign o_now_x   = r_track_x;
    assign o_now_y   = r_track_y;
    assign o_travel  = r_travel;

endmodule

FILE: hw/rtl/tamp_ctrl.sv
// Controller: steps one request through check (moves: product, divide) and owns handshakes.
module tamp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output tamp_pkg::t_dp_cmd o_cmd,
    input  tamp_pkg::t_dp_sts i_sts
);

    localparam int unsigned CW = tamp_pkg::CNT_W;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EVAL = 6'b000010,
        S_MAG  = 6'b000100,
        S_MUL  = 6'b001000,
        S_DIV  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_out_valid, n_out_valid;
    logic          w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = S_MAG;
            end
            S_MAG: begin
                o_cmd.mag = 1'b1;
                n_state   = i_sts.proceed ? S_MUL : S_DONE;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_cnt     = '0;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + CW'(1);
                if (r_cnt == CW'(tamp_pkg::DIV_STEPS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the result word has somewhere to go
                if (w_slot_free) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: hw/rtl/two_axis_synchronized_move_planner.sv
// Two-axis synchronized move planner: limits check, deltas, per-axis rates, tracked position.
//
// One request is worked on at a time. A move goes from acceptance to its result word
// through capture, limit check and deltas, magnitudes, the rate product, 20 steps of the
// radix-2 divider that gives the minor-axis rate, and the result write. Home, abort, a
// rejected move, a move to the current position and an unused request code skip the
// product and the divider. The result sits in an output register, so the next request
// is taken as soon as the result is written there, even if it has not been read; a later
// result waits until that register is free. Configuration writes take effect on the next
// clock; the user must make them only while no request is in work; the block has no check.
module two_axis_synchronized_move_planner #(
    parameter int unsigned POS_BITS = tamp_pkg::POS_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // dest_x, dest_y
    input  logic [((2*POS_BITS+7)/8)*8-1:0]        s_axis_tdata,
    // req_type
    input  logic [tamp_pkg::REQ_W-1:0]             s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // move_dx, move_dy, rate_x, rate_y, now_x, now_y, travel
    output logic [((5*POS_BITS+42+7)/8)*8-1:0]     m_axis_tdata,
    // status, command_kind
    output logic [tamp_pkg::OUT_USER_W-1:0]        m_axis_tuser,
    input  logic                                   i_cfg_wr_en,
    input  logic [tamp_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [tamp_pkg::CFG_W-1:0]             i_cfg_wr_data
);

    localparam int unsigned P     = POS_BITS;
    localparam int unsigned OUT_W = ((5*POS_BITS+42+7)/8)*8;

    tamp_pkg::t_dp_cmd               w_cmd;
    tamp_pkg::t_dp_sts               w_sts;
    logic [tamp_pkg::STATUS_W-1:0]   w_status;
    logic [tamp_pkg::KIND_W-1:0]     w_kind;
    logic signed [P:0]               w_move_dx, w_move_dy;
    logic [tamp_pkg::RATE_W-1:0]     w_rate_x, w_rate_y;
    logic signed [P-1:0]             w_now_x, w_now_y;
    logic [P-1:0]                    w_travel;

    tamp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    tamp_dp #(
        .POS_BITS (POS_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_req         (s_axis_tuser),
        .i_dest_x      (s_axis_tdata[P-1:0]),
        .i_dest_y      (s_axis_tdata[2*P-1:P]),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_status      (w_status),
        .o_kind        (w_kind),
        .o_move_dx     (w_move_dx),
        .o_move_dy     (w_move_dy),
        .o_rate_x      (w_rate_x),
        .o_rate_y      (w_rate_y),
        .o_now_x       (w_now_x),
        .o_now_y       (w_now_y),
        .o_travel      (w_travel)
    );

    assign m_axis_tdata = OUT_W'({w_travel, w_now_y, w_now_x, w_rate_y, w_rate_x,
                                  w_move_dy, w_move_dx});
    assign m_axis_tuser = {w_kind, w_status};

endmodule

FILE: hw/rtl/tamp_checker.sv
// Port-level checker for the move planner, bound to the top level.
`include "assert_macros.svh"

module tamp_checker #(
    parameter int unsigned POS_BITS = tamp_pkg::POS_BITS_DEF
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [((5*POS_BITS+42+7)/8)*8-1:0]  m_axis_tdata,
    input logic [tamp_pkg::OUT_USER_W-1:0]     m_axis_tuser
);

    localparam int unsigned SW   = tamp_pkg::STATUS_W;
    localparam int unsigned RW   = tamp_pkg::RATE_W;
    localparam int unsigned RX_L = 2*(POS_BITS+1);
    localparam int unsigned RY_L = RX_L + RW;

    logic [SW-1:0]                 w_status;
    logic [tamp_pkg::KIND_W-1:0]   w_kind;
    logic [RW-1:0]                 w_rate_x, w_rate_y;

    assign w_status = m_axis_tuser[SW-1:0];
    assign w_kind   = m_axis_tuser[tamp_pkg::OUT_USER_W-1:SW];
    assign w_rate_x = m_axis_tdata[RX_L+RW-1:RX_L];
    assign w_rate_y = m_axis_tdata[RY_L+RW-1:RY_L];

    `TAMP_ASSERT_RST(a_reset_no_word, i_clk, i_rst_n, !m_axis_tvalid)

    `TAMP_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    `TAMP_ASSERT(a_one_in_work, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)

    `TAMP_ASSERT(a_reject_no_cmd, i_clk, i_rst_n, m_axis_tvalid && w_status != tamp_pkg::ST_DONE |-> w_kind == tamp_pkg::CMD_NONE && w_rate_x == '0 && w_rate_y == '0)

    `TAMP_ASSERT(a_x_only_rates, i_clk, i_rst_n, m_axis_tvalid && w_kind == tamp_pkg::CMD_MOVE_X |-> w_rate_x != '0 && w_rate_y == '0)

endmodule

bind two_axis_synchronized_move_planner tamp_checker #(.POS_BITS(POS_BITS)) u_tamp_checker (.*);
